// ===== hdl/blt_pkg.sv =====
// ----------------------------------------------------------------------------
// BASIC token lexer package
// Token kinds, scan modes, character codes, keyword table and shared types.
// ----------------------------------------------------------------------------
package blt_pkg;

  localparam int MAX_SOURCE_BYTES  = 65536;
  localparam int KEYWORD_CHARS_DEF = 6;
  localparam int KW_MAX_CHARS      = 6;
  localparam int KW_COUNT          = 12;
  localparam int QUEUE_DEPTH       = 4;

  localparam int POS_CAP_INT = (MAX_SOURCE_BYTES - 1 < 65535) ? MAX_SOURCE_BYTES - 1 : 65535;
  localparam logic [15:0] POS_CAP = 16'(POS_CAP_INT);

  typedef enum logic [4:0] {
    KIND_LET    = 5'd0,
    KIND_PRINT  = 5'd1,
    KIND_INPUT  = 5'd2,
    KIND_GOSUB  = 5'd3,
    KIND_RETURN = 5'd4,
    KIND_REM    = 5'd5,
    KIND_GOTO   = 5'd6,
    KIND_CALL   = 5'd7,
    KIND_THEN   = 5'd8,
    KIND_ELSE   = 5'd9,
    KIND_ENDKW  = 5'd10,
    KIND_IF     = 5'd11,
    KIND_ID     = 5'd12,
    KIND_NUM    = 5'd13,
    KIND_STR    = 5'd14,
    KIND_PLUS   = 5'd15,
    KIND_MINUS  = 5'd16,
    KIND_STAR   = 5'd17,
    KIND_SLASH  = 5'd18,
    KIND_LPAREN = 5'd19,
    KIND_RPAREN = 5'd20,
    KIND_COMMA  = 5'd21,
    KIND_SEMI   = 5'd22,
    KIND_EQ     = 5'd23,
    KIND_CARET  = 5'd24,
    KIND_LT     = 5'd25,
    KIND_LE     = 5'd26,
    KIND_NE     = 5'd27,
    KIND_GT     = 5'd28,
    KIND_GE     = 5'd29,
    KIND_EOS    = 5'd30
  } kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUM,
    MODE_STR,
    MODE_COMMENT,
    MODE_LT,
    MODE_GT
  } mode_e;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_LP    = 8'h28;
  localparam logic [7:0] CH_RP    = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_US    = 8'h5F;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  // keyword text, right-aligned in 48 bits
  localparam logic [47:0] KW_STR [KW_COUNT] = '{
    {24'h0, "LET"}, {8'h0, "PRINT"}, {8'h0, "INPUT"}, {8'h0, "GOSUB"},
    "RETURN", {24'h0, "REM"}, {16'h0, "GOTO"}, {16'h0, "CALL"},
    {16'h0, "THEN"}, {16'h0, "ELSE"}, {24'h0, "END"}, {32'h0, "IF"}
  };
  localparam int KW_LEN [KW_COUNT] = '{3, 5, 5, 5, 6, 3, 4, 4, 4, 4, 3, 2};

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } kw_res_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] offset;
    logic [15:0] length;
  } tok_t;

  typedef struct packed {
    logic        two;
    tok_t        tok0;
    tok_t        tok1;
    logic [15:0] line;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic kw_res_t kw_match(input logic [KW_MAX_CHARS-1:0][6:0] b,
                                       input logic [15:0] len);
    kw_res_t r;
    logic    eq;
    r = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      eq = (len == 16'(KW_LEN[k]));
      for (int i = 0; i < KW_MAX_CHARS; i++) begin
        if (i < KW_LEN[k]) begin
          eq = eq && (b[i] == KW_STR[k][8*(KW_LEN[k]-1-i) +: 7]);
        end
      end
      if (eq && !r.hit) begin
        r.hit = 1'b1;
        r.idx = 4'(k);
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/blt_if.sv =====
// ----------------------------------------------------------------------------
// BASIC token lexer channels
// Valid/ready channels for source items and token items.
// ----------------------------------------------------------------------------
interface blt_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] ch;

  modport source (output valid, output func, output ch, input ready);
  modport sink (input valid, input func, input ch, output ready);
endinterface

interface blt_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  kind;
  logic [15:0] text_offset;
  logic [15:0] text_length;
  logic [15:0] line_number;
  logic        last;

  modport source (output valid, output kind, output text_offset, output text_length,
                  output line_number, output last, input ready);
  modport sink (input valid, input kind, input text_offset, input text_length,
                input line_number, input last, output ready);
endinterface

// ===== hdl/blt_front.sv =====
// ----------------------------------------------------------------------------
// BASIC token lexer front end
// Scan state machine: takes one byte per cycle while the record queue is not full, forms up to two tokens.
// ----------------------------------------------------------------------------
module blt_front #(
  parameter int KEYWORD_CHARS = blt_pkg::KEYWORD_CHARS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [15:0]    cfg_wdata_i,
  blt_in_if.sink         in_if,
  input  logic           q_full_i,
  output logic           push_o,
  output blt_pkg::rec_t  rec_o
);
  import blt_pkg::*;

  localparam int KW = $clog2(KEYWORD_CHARS);

  mode_e       mode_q, mode_d;
  logic [15:0] tstart_q, tstart_d;
  logic [15:0] tlen_q, tlen_d;
  logic [KEYWORD_CHARS-1:0][6:0] buf_q, buf_d;
  logic        wtl_q, wtl_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] line_q, line_d;
  logic        lht_q, lht_d;
  logic [15:0] start_line_q;

  logic        accept;
  logic [7:0]  c;
  logic [6:0]  up_ch;
  logic        is_digit, is_id_more;
  kw_res_t     kw;
  logic        kw_hit, id_is_rem;
  tok_t        id_tok;
  logic        p1_v, p2_v, go, lf_hit;
  tok_t        p1, p2;
  logic [15:0] tlen_inc;

  assign in_if.ready = !q_full_i;
  assign accept      = in_if.valid && in_if.ready;
  assign c           = in_if.ch;

  always_comb begin
    is_digit   = (c >= CH_D0) && (c <= CH_D9);
    is_id_more = is_digit || ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ))
                 || (c == CH_US) || (c == CH_DOT);
    up_ch      = ((c >= CH_LA) && (c <= CH_LZ)) ? 7'(c - 8'h20) : c[6:0];
    tlen_inc   = (tlen_q != 16'hFFFF) ? tlen_q + 16'd1 : tlen_q;
    kw         = kw_match(buf_q[KW_MAX_CHARS-1:0], tlen_q);
    kw_hit     = kw.hit && !wtl_q && (tlen_q <= 16'(KEYWORD_CHARS));
    id_is_rem  = kw_hit && (5'(kw.idx) == KIND_REM);
    id_tok     = kw_hit ? tok_t'{5'(kw.idx), tstart_q, 16'd0}
                        : tok_t'{KIND_ID, tstart_q, tlen_q};
  end

  always_comb begin
    mode_d   = mode_q;
    tstart_d = tstart_q;
    tlen_d   = tlen_q;
    buf_d    = buf_q;
    wtl_d    = wtl_q;
    pos_d    = pos_q;
    line_d   = line_q;
    p1_v     = 1'b0;
    p1       = '0;
    p2_v     = 1'b0;
    p2       = '0;
    go       = 1'b0;
    lf_hit   = 1'b0;
    if (in_if.func) begin
      unique case (mode_q)
        MODE_IDENT: begin
          p1_v = !(id_is_rem && lht_q);
          p1   = id_tok;
        end
        MODE_NUM: begin
          p1_v = 1'b1;
          p1   = '{KIND_NUM, tstart_q, tlen_q};
        end
        MODE_STR: begin
          p1_v = 1'b1;
          p1   = '{KIND_STR, tstart_q, tlen_q};
        end
        MODE_LT: begin
          p1_v = 1'b1;
          p1   = '{KIND_LT, tstart_q, 16'd0};
        end
        MODE_GT: begin
          p1_v = 1'b1;
          p1   = '{KIND_GT, tstart_q, 16'd0};
        end
        default: ;
      endcase
      p2_v     = 1'b1;
      p2       = '{KIND_EOS, pos_q, 16'd0};
      mode_d   = MODE_IDLE;
      pos_d    = '0;
      line_d   = start_line_q;
      tstart_d = '0;
      tlen_d   = '0;
    end else begin
      go = 1'b1;
      unique case (mode_q)
        MODE_IDENT: begin
          if (is_id_more) begin
            go = 1'b0;
            if (tlen_q < 16'(KEYWORD_CHARS)) begin
              buf_d[tlen_q[KW-1:0]] = up_ch;
            end else begin
              wtl_d = 1'b1;
            end
            tlen_d = tlen_inc;
          end else begin
            mode_d = id_is_rem ? MODE_COMMENT : MODE_IDLE;
            p1_v   = !(id_is_rem && lht_q);
            p1     = id_tok;
          end
        end
        MODE_NUM: begin
          if (is_digit || c == CH_DOT) begin
            go     = 1'b0;
            tlen_d = tlen_inc;
          end else begin
            mode_d = MODE_IDLE;
            p1_v   = 1'b1;
            p1     = '{KIND_NUM, tstart_q, tlen_q};
          end
        end
        MODE_STR: begin
          go = 1'b0;
          if (c == CH_DQ) begin
            mode_d = MODE_IDLE;
            p1_v   = 1'b1;
            p1     = '{KIND_STR, tstart_q, tlen_q};
          end else begin
            tlen_d = tlen_inc;
          end
        end
        MODE_LT: begin
          mode_d = MODE_IDLE;
          p1_v   = 1'b1;
          if (c == CH_EQ) begin
            go = 1'b0;
            p1 = '{KIND_LE, tstart_q, 16'd0};
          end else if (c == CH_GT) begin
            go = 1'b0;
            p1 = '{KIND_NE, tstart_q, 16'd0};
          end else begin
            p1 = '{KIND_LT, tstart_q, 16'd0};
          end
        end
        MODE_GT: begin
          mode_d = MODE_IDLE;
          p1_v   = 1'b1;
          if (c == CH_EQ) begin
            go = 1'b0;
            p1 = '{KIND_GE, tstart_q, 16'd0};
          end else begin
            p1 = '{KIND_GT, tstart_q, 16'd0};
          end
        end
        default: ;
      endcase
      if (go && mode_d == MODE_COMMENT && c != CH_LF && c != CH_CR) begin
        go = 1'b0;
      end
      if (go) begin
        mode_d = MODE_IDLE;
        unique case (c) inside
          CH_SP, CH_TAB, CH_CR: ;
          CH_LF: begin
            lf_hit = 1'b1;
            line_d = (line_q != 16'hFFFF) ? line_q + 16'd1 : line_q;
          end
          CH_SQ: begin
            p2_v   = !(lht_q || p1_v);
            p2     = '{KIND_REM, pos_q, 16'd0};
            mode_d = MODE_COMMENT;
          end
          CH_DQ: begin
            mode_d   = MODE_STR;
            tstart_d = (pos_q < POS_CAP) ? pos_q + 16'd1 : POS_CAP;
            tlen_d   = '0;
          end
          CH_PLUS:  begin p2_v = 1'b1; p2 = '{KIND_PLUS, pos_q, 16'd0}; end
          CH_MINUS: begin p2_v = 1'b1; p2 = '{KIND_MINUS, pos_q, 16'd0}; end
          CH_STAR:  begin p2_v = 1'b1; p2 = '{KIND_STAR, pos_q, 16'd0}; end
          CH_SLASH: begin p2_v = 1'b1; p2 = '{KIND_SLASH, pos_q, 16'd0}; end
          CH_LP:    begin p2_v = 1'b1; p2 = '{KIND_LPAREN, pos_q, 16'd0}; end
          CH_RP:    begin p2_v = 1'b1; p2 = '{KIND_RPAREN, pos_q, 16'd0}; end
          CH_COMMA: begin p2_v = 1'b1; p2 = '{KIND_COMMA, pos_q, 16'd0}; end
          CH_SEMI:  begin p2_v = 1'b1; p2 = '{KIND_SEMI, pos_q, 16'd0}; end
          CH_EQ:    begin p2_v = 1'b1; p2 = '{KIND_EQ, pos_q, 16'd0}; end
          CH_CARET: begin p2_v = 1'b1; p2 = '{KIND_CARET, pos_q, 16'd0}; end
          CH_LT: begin
            mode_d   = MODE_LT;
            tstart_d = pos_q;
          end
          CH_GT: begin
            mode_d   = MODE_GT;
            tstart_d = pos_q;
          end
          [CH_D0:CH_D9]: begin
            mode_d   = MODE_NUM;
            tstart_d = pos_q;
            tlen_d   = 16'd1;
          end
          [CH_UA:CH_UZ], [CH_LA:CH_LZ], CH_US, CH_DOT: begin
            mode_d   = MODE_IDENT;
            tstart_d = pos_q;
            tlen_d   = 16'd1;
            wtl_d    = 1'b0;
            buf_d[0] = up_ch;
          end
          default: ;
        endcase
      end
      pos_d = (pos_q < POS_CAP) ? pos_q + 16'd1 : pos_q;
    end
    lht_d = (in_if.func || lf_hit) ? 1'b0 : (lht_q || p1_v || p2_v);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      tstart_q     <= '0;
      tlen_q       <= '0;
      wtl_q        <= 1'b0;
      pos_q        <= '0;
      line_q       <= 16'd1;
      lht_q        <= 1'b0;
      start_line_q <= 16'd1;
    end else if (cfg_we_i) begin
      start_line_q <= cfg_wdata_i;
      line_q       <= cfg_wdata_i;
    end else if (accept) begin
      mode_q   <= mode_d;
      tstart_q <= tstart_d;
      tlen_q   <= tlen_d;
      wtl_q    <= wtl_d;
      pos_q    <= pos_d;
      line_q   <= line_d;
      lht_q    <= lht_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      buf_q <= buf_d;
    end
  end

  assign push_o     = accept && (p1_v || p2_v);
  assign rec_o.two  = p1_v && p2_v;
  assign rec_o.tok0 = p1_v ? p1 : p2;
  assign rec_o.tok1 = p2;
  assign rec_o.line = line_q;

endmodule

// ===== hdl/blt_queue.sv =====
// ----------------------------------------------------------------------------
// BASIC token lexer record queue
// Small FIFO of token records between the scanner and the output stage.
// ----------------------------------------------------------------------------
module blt_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  blt_pkg::rec_t    rec_i,
  input  logic             pop_i,
  output blt_pkg::rec_t    head_o,
  output blt_pkg::q_stat_t stat_o
);
  import blt_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  rec_t        mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [PW:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= rec_i;
    end
  end

  assign head_o       = mem_q[rptr_q];
  assign stat_o.full  = (cnt_q == (PW+1)'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

// ===== hdl/blt_back.sv =====
// ----------------------------------------------------------------------------
// BASIC token lexer back end
// Splits each record into token items and holds them in the output register.
// ----------------------------------------------------------------------------
module blt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  blt_pkg::rec_t    head_i,
  input  blt_pkg::q_stat_t stat_i,
  output logic             pop_o,
  blt_out_if.source        out_if
);
  import blt_pkg::*;

  logic        ovalid_q;
  logic        sel_q;
  tok_t        tok_q;
  logic [15:0] line_q;
  logic        last_q;
  logic        load, take, is_last;
  tok_t        cur;

  always_comb begin
    load    = !ovalid_q || out_if.ready;
    take    = load && !stat_i.empty;
    cur     = sel_q ? head_i.tok1 : head_i.tok0;
    is_last = !head_i.two || sel_q;
    pop_o   = take && is_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      sel_q    <= 1'b0;
    end else if (load) begin
      ovalid_q <= !stat_i.empty;
      if (take) begin
        sel_q <= !is_last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      tok_q  <= cur;
      line_q <= head_i.line;
      last_q <= is_last;
    end
  end

  assign out_if.valid       = ovalid_q;
  assign out_if.kind        = tok_q.kind;
  assign out_if.text_offset = tok_q.offset;
  assign out_if.text_length = tok_q.length;
  assign out_if.line_number = line_q;
  assign out_if.last        = last_q;

endmodule

// ===== hdl/basic_token_lexer.sv =====
// ----------------------------------------------------------------------------
// BASIC token lexer
// The first token of an item goes into the record queue and then into the
// output register. Input takes one item per cycle while the record queue
// has room; the output stage sends one token per cycle while the receiver
// is ready, so two tokens of one item leave in turn. Reset is asynchronous:
// scanner idle, start line 1, queue and output empty; no clearing pass.
// ----------------------------------------------------------------------------
module basic_token_lexer #(
  parameter int KEYWORD_CHARS = blt_pkg::KEYWORD_CHARS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  blt_in_if.sink      in_if,
  blt_out_if.source   out_if
);
  import blt_pkg::*;

  logic    q_push, q_pop;
  rec_t    rec, head;
  q_stat_t q_stat;

  blt_front #(
    .KEYWORD_CHARS(KEYWORD_CHARS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if),
    .q_full_i   (q_stat.full),
    .push_o     (q_push),
    .rec_o      (rec)
  );

  blt_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(q_push),
    .rec_i (rec),
    .pop_i (q_pop),
    .head_o(head),
    .stat_o(q_stat)
  );

  blt_back u_back (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .head_i(head),
    .stat_i(q_stat),
    .pop_o (q_pop),
    .out_if(out_if)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_stat.full))
    else $error("record pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_stat.empty))
    else $error("record popped from empty queue");

  a_eos_enqueued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready && in_if.func) |-> q_push)
    else $error("end of source item gave no record");

  a_out_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_stat.empty && !out_if.valid) |=> out_if.valid)
    else $error("output stage idle with queued records");

endmodule

// ===== tb/sv/tb_basic_token_lexer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BASIC token lexer testbench
// Feeds source items and end-of-source marks to the lexer and checks every
// token it emits against a token predictor kept in the testbench. Covers a
// directed program, start line settings up to line saturation, a long
// receiver hold-off, random BASIC-like programs and a gap-free tail.
// ----------------------------------------------------------------------------
module tb_basic_token_lexer;
  import blt_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 1400;
  localparam int TAIL_STRING  = 60;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] offset;
    logic [15:0] length;
    logic [15:0] line;
    logic        last;
  } token_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  blt_in_if  in_ch ();
  blt_out_if out_ch ();

  basic_token_lexer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  string kw_names [12] = '{"LET", "PRINT", "INPUT", "GOSUB", "RETURN", "REM",
                           "GOTO", "CALL", "THEN", "ELSE", "END", "IF"};
  string op_names [15] = '{"+", "-", "*", "/", "(", ")", ",", ";", "=", "^",
                           "<", "<=", "<>", ">", ">="};

  // expected tokens, oldest first
  token_t pending_tokens [$];
  token_t step_toks [2];
  int     step_n;

  // lexer state as predicted
  mode_e       lx_mode;
  logic [15:0] lx_start;
  logic [15:0] lx_len;
  logic [15:0] lx_pos;
  logic [15:0] lx_line;
  logic [15:0] cfg_start;
  logic [7:0]  lx_kw [6];
  logic        lx_long;
  logic        lx_busy;

  int err_cnt        = 0;
  int items_sent     = 0;
  int tokens_checked = 0;
  int sources_sent   = 0;
  int cfg_writes     = 0;
  int cycle_cnt      = 0;
  int hold_req       = 0;
  int hold_cnt       = 0;
  int stall_cnt      = 0;
  bit tx_idle_en     = 1'b0;
  bit rx_idle_en     = 1'b0;

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_D0 && c <= CH_D9;
  endfunction

  function automatic bit is_word_first(logic [7:0] c);
    return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ) ||
           c == CH_US || c == CH_DOT;
  endfunction

  function automatic logic [7:0] to_upper(logic [7:0] c);
    return (c >= CH_LA && c <= CH_LZ) ? c - 8'h20 : c;
  endfunction

  function automatic void emit_tok(kind_e k, logic [15:0] off, logic [15:0] len);
    if (step_n < 2) begin
      step_toks[step_n] = '{kind: k, offset: off, length: len, line: lx_line, last: 1'b0};
      step_n++;
    end
    lx_busy = 1'b1;
  endfunction

  function automatic int find_keyword();
    bit hit;
    if (lx_long || lx_len > 6) return -1;
    for (int k = 0; k < 12; k++) begin
      if (kw_names[k].len() == lx_len) begin
        hit = 1'b1;
        for (int i = 0; i < kw_names[k].len(); i++) begin
          if (lx_kw[i] != kw_names[k][i]) hit = 1'b0;
        end
        if (hit) return k;
      end
    end
    return -1;
  endfunction

  function automatic void finish_word();
    int k;
    k = find_keyword();
    lx_mode = MODE_IDLE;
    if (k < 0) begin
      emit_tok(KIND_ID, lx_start, lx_len);
    end else if (kind_e'(k) == KIND_REM) begin
      if (!lx_busy) emit_tok(KIND_REM, lx_start, 16'd0);
      lx_mode = MODE_COMMENT;
    end else begin
      emit_tok(kind_e'(k), lx_start, 16'd0);
    end
  endfunction

  function automatic void take_byte(logic [7:0] c, logic [15:0] pos);
    case (lx_mode)
      MODE_IDENT: begin
        if (is_word_first(c) || is_digit(c)) begin
          if (lx_len < 6) lx_kw[lx_len[2:0]] = to_upper(c);
          else lx_long = 1'b1;
          if (lx_len != 16'hFFFF) lx_len++;
          return;
        end
        finish_word();
      end
      MODE_NUM: begin
        if (is_digit(c) || c == CH_DOT) begin
          if (lx_len != 16'hFFFF) lx_len++;
          return;
        end
        emit_tok(KIND_NUM, lx_start, lx_len);
        lx_mode = MODE_IDLE;
      end
      MODE_STR: begin
        if (c == CH_DQ) begin
          lx_mode = MODE_IDLE;
          emit_tok(KIND_STR, lx_start, lx_len);
          return;
        end
        if (lx_len != 16'hFFFF) lx_len++;
        return;
      end
      MODE_LT: begin
        lx_mode = MODE_IDLE;
        if (c == CH_EQ) begin
          emit_tok(KIND_LE, lx_start, 16'd0);
          return;
        end
        if (c == CH_GT) begin
          emit_tok(KIND_NE, lx_start, 16'd0);
          return;
        end
        emit_tok(KIND_LT, lx_start, 16'd0);
      end
      MODE_GT: begin
        lx_mode = MODE_IDLE;
        if (c == CH_EQ) begin
          emit_tok(KIND_GE, lx_start, 16'd0);
          return;
        end
        emit_tok(KIND_GT, lx_start, 16'd0);
      end
      default: ;
    endcase
    // comment swallows everything up to a line end
    if (lx_mode == MODE_COMMENT && c != CH_LF && c != CH_CR) return;
    lx_mode = MODE_IDLE;
    case (c)
      CH_SP, CH_TAB, CH_CR: ;
      CH_LF: begin
        if (lx_line != 16'hFFFF) lx_line++;
        lx_busy = 1'b0;
      end
      CH_SQ: begin
        if (!lx_busy) emit_tok(KIND_REM, pos, 16'd0);
        lx_mode = MODE_COMMENT;
      end
      CH_DQ: begin
        lx_mode  = MODE_STR;
        lx_start = (pos < POS_CAP) ? pos + 16'd1 : POS_CAP;
        lx_len   = 16'd0;
      end
      CH_PLUS:  emit_tok(KIND_PLUS, pos, 16'd0);
      CH_MINUS: emit_tok(KIND_MINUS, pos, 16'd0);
      CH_STAR:  emit_tok(KIND_STAR, pos, 16'd0);
      CH_SLASH: emit_tok(KIND_SLASH, pos, 16'd0);
      CH_LP:    emit_tok(KIND_LPAREN, pos, 16'd0);
      CH_RP:    emit_tok(KIND_RPAREN, pos, 16'd0);
      CH_COMMA: emit_tok(KIND_COMMA, pos, 16'd0);
      CH_SEMI:  emit_tok(KIND_SEMI, pos, 16'd0);
      CH_EQ:    emit_tok(KIND_EQ, pos, 16'd0);
      CH_CARET: emit_tok(KIND_CARET, pos, 16'd0);
      CH_LT: begin
        lx_mode  = MODE_LT;
        lx_start = pos;
      end
      CH_GT: begin
        lx_mode  = MODE_GT;
        lx_start = pos;
      end
      default: begin
        if (is_digit(c)) begin
          lx_mode  = MODE_NUM;
          lx_start = pos;
          lx_len   = 16'd1;
        end else if (is_word_first(c)) begin
          lx_mode  = MODE_IDENT;
          lx_start = pos;
          lx_len   = 16'd1;
          lx_long  = 1'b0;
          lx_kw[0] = to_upper(c);
        end
      end
    endcase
  endfunction

  function automatic void predict_tokens(logic f, logic [7:0] c);
    step_n = 0;
    if (f) begin
      case (lx_mode)
        MODE_IDENT: finish_word();
        MODE_NUM:   emit_tok(KIND_NUM, lx_start, lx_len);
        MODE_STR:   emit_tok(KIND_STR, lx_start, lx_len);
        MODE_LT:    emit_tok(KIND_LT, lx_start, 16'd0);
        MODE_GT:    emit_tok(KIND_GT, lx_start, 16'd0);
        default: ;
      endcase
      emit_tok(KIND_EOS, lx_pos, 16'd0);
      lx_mode  = MODE_IDLE;
      lx_pos   = 16'd0;
      lx_line  = cfg_start;
      lx_busy  = 1'b0;
      lx_start = 16'd0;
      lx_len   = 16'd0;
    end else begin
      take_byte(c, lx_pos);
      if (lx_pos < POS_CAP) lx_pos++;
    end
    for (int i = 0; i < step_n; i++) begin
      if (i == step_n - 1) step_toks[i].last = 1'b1;
      pending_tokens = {pending_tokens, step_toks[i]};
    end
  endfunction

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      report_error($sformatf("token %0d %s: got %0d, expected %0d",
                             tokens_checked, name, got, want));
    end
  endtask

  // token side: check accepted tokens, drive ready with stalls and hold-off
  always @(posedge clk_i) begin : token_side
    token_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_tokens.size() == 0) begin
        report_error($sformatf("token kind %0d offset %0d with nothing expected",
                               out_ch.kind, out_ch.text_offset));
      end else begin
        want = pending_tokens.pop_front();
        check_field("kind", 16'(out_ch.kind), 16'(want.kind));
        check_field("offset", out_ch.text_offset, want.offset);
        check_field("length", out_ch.text_length, want.length);
        check_field("line", out_ch.line_number, want.line);
        check_field("last", 16'(out_ch.last), 16'(want.last));
        tokens_checked++;
      end
    end
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ch.ready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      out_ch.ready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 11) == 0) begin
      stall_cnt = $urandom_range(1, 19) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d tokens outstanding",
               cycle_cnt, pending_tokens.size());
      $display("basic_token_lexer test failed");
      $finish;
    end
  end

  task automatic send_item(logic f, logic [7:0] c);
    if (tx_idle_en && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= f;
    in_ch.ch    <= c;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_tokens(f, c);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
  endtask

  task automatic end_source();
    send_item(1'b1, 8'($urandom_range(0, 255)));
    sources_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_start_line(logic [15:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    cfg_start = v;
    lx_line   = v;
    cfg_writes++;
  endtask

  function automatic logic [7:0] word_char();
    case ($urandom_range(0, 4))
      0:       return CH_UA + 8'($urandom_range(0, 25));
      1:       return CH_LA + 8'($urandom_range(0, 25));
      2:       return CH_D0 + 8'($urandom_range(0, 9));
      3:       return CH_US;
      default: return CH_DOT;
    endcase
  endfunction

  task automatic send_lexeme();
    int          n;
    int          k;
    logic [7:0]  c;
    case ($urandom_range(0, 11))
      0, 1: begin
        k = $urandom_range(0, 11);
        for (int i = 0; i < kw_names[k].len(); i++) begin
          c = kw_names[k][i];
          if ($urandom_range(0, 1) != 0) c = c | 8'h20;
          send_item(1'b0, c);
        end
      end
      2, 3: begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
        do c = word_char(); while (is_digit(c));
        send_item(1'b0, c);
        repeat (n - 1) send_item(1'b0, word_char());
      end
      4: begin
        send_item(1'b0, CH_D0 + 8'($urandom_range(0, 9)));
        repeat ($urandom_range(0, 5)) begin
          send_item(1'b0, ($urandom_range(0, 4) == 0) ? CH_DOT :
                          CH_D0 + 8'($urandom_range(0, 9)));
        end
      end
      5: begin
        send_item(1'b0, CH_DQ);
        repeat ($urandom_range(0, 8)) begin
          c = 8'($urandom_range(0, 255));
          send_item(1'b0, (c == CH_DQ) ? CH_LF : c);
        end
        if ($urandom_range(0, 9) != 0) send_item(1'b0, CH_DQ);
      end
      6, 7: send_text(op_names[$urandom_range(0, 14)]);
      8: begin
        case ($urandom_range(0, 4))
          0:       send_text(" ");
          1:       send_text("\t");
          2:       send_text("\n");
          3:       send_text("\r\n");
          default: send_text("\r");
        endcase
      end
      9: begin
        if ($urandom_range(0, 1) != 0) send_text("'");
        else send_text(($urandom_range(0, 1) != 0) ? "REM " : "rem");
        repeat ($urandom_range(0, 6)) begin
          c = 8'($urandom_range(0, 255));
          send_item(1'b0, (c == CH_LF || c == CH_CR) ? CH_SP : c);
        end
        send_item(1'b0, ($urandom_range(0, 3) == 0) ? CH_CR : CH_LF);
      end
      10:      send_item(1'b0, 8'($urandom_range(0, 255)));
      default: send_text(" ");
    endcase
    if ($urandom_range(0, 2) != 0) send_text(" ");
  endtask

  task automatic test_directed();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    // REM heading a line, ids, numbers, two-char operators, string with LF,
    // quote comment after a token, lone '<', unknown bytes, unclosed string
    send_text("REM z\n");
    send_text("x.1<>9>=\"a\nb");
    send_item(1'b0, 8'hFF);
    send_text("\"'c\r<");
    send_item(1'b0, 8'h00);
    send_text("\"u");
    send_item(1'b1, 8'hA5);
    sources_sent++;
  endtask

  task automatic test_line_numbers();
    logic [15:0] vals [5];
    vals = '{16'd0, 16'd65533, 16'hFFFF, 16'($urandom_range(2, 65532)), 16'd1};
    for (int i = 0; i < 5; i++) begin
      write_start_line(vals[i]);
      if (i == 0) end_source();
      repeat (4) send_text("a=1\n");
      send_text("b'x");
      end_source();
    end
  endtask

  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    wait_drained();
    hold_req = HOLD_CYCLES;
    repeat (40) send_text("+x ");
    end_source();
  endtask

  task automatic test_random_sources();
    int goal;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 25)) send_lexeme();
      end_source();
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 3))
          0:       write_start_line(16'd0);
          1:       write_start_line(16'hFFFF);
          2:       write_start_line(16'($urandom_range(0, 65535)));
          default: write_start_line(16'd1);
        endcase
      end
    end
  endtask

  task automatic test_no_idle_tail();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    write_start_line(16'd1);
    // long string, then an operator, an identifier and an unclosed string, with no idling
    send_item(1'b0, CH_DQ);
    repeat (TAIL_STRING) send_item(1'b0, 8'($urandom_range(CH_LA, CH_LZ)));
    send_text("\"+A\"");
    end_source();
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = 16'd0;
    in_ch.valid  = 1'b0;
    in_ch.func   = 1'b0;
    in_ch.ch     = 8'd0;
    out_ch.ready = 1'b0;
    cfg_start    = 16'd1;
    lx_mode      = MODE_IDLE;
    lx_start     = 16'd0;
    lx_len       = 16'd0;
    lx_pos       = 16'd0;
    lx_line      = 16'd1;
    lx_long      = 1'b0;
    lx_busy      = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_line_numbers();
    test_backpressure();
    test_random_sources();
    test_no_idle_tail();
    wait_drained();

    $display("Ran %0d sources, %0d items and %0d start line writes;", sources_sent,
             items_sent, cfg_writes);
    $display("checked %0d tokens, %0d errors, in %0d cycles.", tokens_checked, err_cnt,
             cycle_cnt);
    if (err_cnt == 0) begin
      $display("basic_token_lexer test passed");
    end else begin
      $display("basic_token_lexer test failed");
    end
    $finish;
  end

endmodule
